FILE: hdl/sorted_boundary_snap_core_assert.svh
// Assertion macros for the boundary snap core.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef SORTED_BOUNDARY_SNAP_CORE_ASSERT_SVH
`define SORTED_BOUNDARY_SNAP_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SBS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/sbs_pkg.sv
// Shared types, widths and codes for the boundary snap core.
// No dependencies; compiled first.
package sbs_pkg;

	localparam int SBS_MAX_BOUNDARIES = 256;

	localparam int SLOT_W     = 8;
	localparam int POS_W      = 16;
	localparam int VAL_W      = 64;
	localparam int CNT_W      = 9;
	localparam int ELEM_W     = 17;
	localparam int TOL_W      = 33;
	localparam int STAT_W     = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 33;
	localparam int HALF_W     = 32;
	localparam int PROD_W     = TOL_W + HALF_W;
	localparam int SUM_W      = PROD_W + HALF_W;

	localparam logic [CNT_W-1:0]  BND_COUNT_RST  = CNT_W'(1);
	localparam logic [ELEM_W-1:0] ELEM_COUNT_RST = ELEM_W'(65536);
	localparam logic [TOL_W-1:0]  TOL_RST        = TOL_W'(64);

	localparam logic OP_WRITE_BND = 1'b0;
	localparam logic OP_SNAP      = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BND_COUNT  = 2'd0,
		CFG_ELEM_COUNT = 2'd1,
		CFG_TOLERANCE  = 2'd2
	} cfg_idx_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_KEPT      = 3'd0,
		STAT_SNAPPED   = 3'd1,
		STAT_PAST_LAST = 3'd2,
		STAT_POS_ERR   = 3'd3,
		STAT_ORDER_ERR = 3'd4,
		STAT_ABORTED   = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		VERD_ADVANCE,
		VERD_BELOW,
		VERD_SNAP
	} verdict_t;

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_FETCH,
		CS_CMP,
		CS_EMIT
	} core_state_t;

	typedef enum logic [2:0] {
		CP_IDLE,
		CP_EVAL,
		CP_MUL_HI,
		CP_SUM,
		CP_REL
	} cmp_phase_t;

	typedef struct packed {
		logic                    start;
		logic signed [VAL_W-1:0] x;
		logic signed [VAL_W-1:0] b;
		logic [TOL_W-1:0]        tol;
	} cmp_req_t;

	typedef struct packed {
		logic     done;
		verdict_t verdict;
	} cmp_rsp_t;

endpackage

FILE: hdl/sbs_if.sv
// Handshake interfaces: item requests, results and configuration writes.
// Depends on sbs_pkg.
interface sbs_req_if;
	import sbs_pkg::*;
	logic                    valid;
	logic                    ready;
	logic                    operation;
	logic [SLOT_W-1:0]       boundary_slot;
	logic [POS_W-1:0]        position;
	logic signed [VAL_W-1:0] sample;
	logic                    first_of_pass;

	modport source (output valid, operation, boundary_slot, position, sample, first_of_pass,
		input ready);
	modport sink (input valid, operation, boundary_slot, position, sample, first_of_pass,
		output ready);
endinterface

interface sbs_rsp_if;
	import sbs_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [POS_W-1:0]        out_position;
	logic signed [VAL_W-1:0] out_value;
	logic [STAT_W-1:0]       status;

	modport source (output valid, out_position, out_value, status, input ready);
	modport sink (input valid, out_position, out_value, status, output ready);
endinterface

interface sbs_cfg_if;
	import sbs_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/sorted_boundary_snap_core.sv
// Channel | modport       | carries
// --------+---------------+-------------------------------------------------------
// req     | sbs_req_if    | table write or snap transaction (operation selects)
// rsp     | sbs_rsp_if    | one result per snap transaction, none for table writes
// cfg     | sbs_cfg_if    | register write: 0 boundary count, 1 element count, 2 tol
//
// Table write: stored as it is accepted. Snap with an early status (aborted, past last,
// range or order error): loaded straight into the output register. Otherwise accept, then
// per boundary visited a table read and an absolute test, or a relative test through
// the shared 33x32 multiplier, then the result goes into the output register.
// Async active-low reset clears control and flags; table contents stay undefined.
// req.ready is low while a snap is in flight or a result waits untaken.
//
// Top level of the boundary snap core; depends on sbs_pkg, sbs_if, sbs_bnd_mem,
// sbs_cmp and the assertion macro header.
`include "sorted_boundary_snap_core_assert.svh"

module sorted_boundary_snap_core #(
	parameter int MAX_BOUNDARIES = sbs_pkg::SBS_MAX_BOUNDARIES
) (
	input logic   clk,
	input logic   arst_n,
	sbs_req_if.sink   req,
	sbs_rsp_if.source rsp,
	sbs_cfg_if.sink   cfg
);
	import sbs_pkg::*;

	// table depth: slot field limits reachable entries
	localparam int TABLE_DEPTH = (MAX_BOUNDARIES < (1 << SLOT_W)) ? MAX_BOUNDARIES
		: (1 << SLOT_W);
	localparam int AW          = $clog2(TABLE_DEPTH);
	localparam int CNT_MAX     = (1 << CNT_W) - 1;
	localparam logic [CNT_W-1:0] COUNT_CAP = (MAX_BOUNDARIES < CNT_MAX)
		? CNT_W'(MAX_BOUNDARIES) : CNT_W'(CNT_MAX);

	// state machine and pass state
	core_state_t             state_q, state_d;
	logic [CNT_W-1:0]        bnd_count_q;
	logic [ELEM_W-1:0]       elem_count_q;
	logic [TOL_W-1:0]        tol_q;
	logic [CNT_W-1:0]        cursor_q;
	logic signed [VAL_W-1:0] prev_q;
	logic                    seen_q, exh_q, abort_q;

	// item in flight
	logic signed [VAL_W-1:0] x_q;
	logic [POS_W-1:0]        pos_q;
	logic [VAL_W-1:0]        res_value_q;
	status_t                 res_status_q;

	// output register
	logic                    out_valid_q;
	logic [POS_W-1:0]        out_pos_q;
	logic [VAL_W-1:0]        out_value_q;
	status_t                 out_status_q;

	// decode
	logic             out_free, accept, is_snap, first;
	logic [CNT_W-1:0] count_eff, cursor_eff, cur_next;
	logic             seen_eff, exh_eff, abort_eff, exh_nxt, abort_nxt;
	logic             early, early_load, snap_go, tbl_wr;
	status_t          early_status, res_status_c;
	logic             cmp_term, adv_any, cur_last, adv_go;
	logic             mem_rd_en;
	logic [AW-1:0]    mem_rd_addr;
	logic [VAL_W-1:0] mem_rdata;
	cmp_req_t         cmp_req;
	cmp_rsp_t         cmp_rsp;

	sbs_bnd_mem #(
		.DEPTH (TABLE_DEPTH)
	) u_mem (
		.clk     (clk),
		.wr_en   (tbl_wr),
		.wr_addr (req.boundary_slot[AW-1:0]),
		.wr_data (VAL_W'(req.sample)),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rdata)
	);

	sbs_cmp u_cmp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (cmp_req),
		.rsp    (cmp_rsp)
	);

	assign out_free  = !out_valid_q || rsp.ready;
	assign count_eff = (bnd_count_q > COUNT_CAP) ? COUNT_CAP : bnd_count_q;

	// accept-time decode: first_of_pass clears pass state before the checks
	always_comb begin
		accept     = req.valid && req.ready;
		is_snap    = req.operation == OP_SNAP;
		first      = req.first_of_pass;
		cursor_eff = first ? '0 : cursor_q;
		seen_eff   = first ? 1'b0 : seen_q;
		exh_eff    = first ? 1'b0 : exh_q;
		abort_eff  = first ? 1'b0 : abort_q;

		early        = 1'b1;
		early_status = STAT_ABORTED;
		exh_nxt      = exh_eff;
		abort_nxt    = abort_eff;
		if (abort_eff) begin
			early_status = STAT_ABORTED;
		end else if (exh_eff || (cursor_eff >= count_eff)) begin
			early_status = STAT_PAST_LAST;
			exh_nxt      = 1'b1;
		end else if ({1'b0, req.position} >= elem_count_q) begin
			early_status = STAT_POS_ERR;
			abort_nxt    = 1'b1;
		end else if (seen_eff && (req.sample < prev_q)) begin
			early_status = STAT_ORDER_ERR;
			abort_nxt    = 1'b1;
		end else begin
			early = 1'b0;
		end

		early_load = accept && is_snap && early;
		snap_go    = accept && is_snap && !early;
		tbl_wr     = accept && !is_snap && (int'(req.boundary_slot) < MAX_BOUNDARIES);
	end

	// cursor walk
	always_comb begin
		cur_next = cursor_q + CNT_W'(1);
		cur_last = cur_next >= count_eff;
		cmp_term = (state_q == CS_CMP) && cmp_rsp.done;
		adv_any  = cmp_term && (cmp_rsp.verdict == VERD_ADVANCE);
		adv_go   = adv_any && !cur_last;
		case (cmp_rsp.verdict)
			VERD_ADVANCE: res_status_c = STAT_PAST_LAST;
			VERD_BELOW:   res_status_c = STAT_KEPT;
			VERD_SNAP:    res_status_c = STAT_SNAPPED;
			default:      res_status_c = STAT_KEPT;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			CS_IDLE:  if (snap_go) state_d = CS_FETCH;
			CS_FETCH: state_d = CS_CMP;
			CS_CMP:   if (cmp_rsp.done) state_d = adv_go ? CS_FETCH : CS_EMIT;
			CS_EMIT:  if (out_free) state_d = CS_IDLE;
			default:  state_d = CS_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		req.ready     = (state_q == CS_IDLE) && out_free;
		cfg.ready     = 1'b1;
		mem_rd_en     = snap_go || adv_go;
		mem_rd_addr   = snap_go ? cursor_eff[AW-1:0] : cur_next[AW-1:0];
		cmp_req.start = state_q == CS_FETCH;
		cmp_req.x     = x_q;
		cmp_req.b     = mem_rdata;
		cmp_req.tol   = tol_q;
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.out_position = out_pos_q;
	assign rsp.out_value    = out_value_q;
	assign rsp.status       = out_status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= CS_IDLE;
			bnd_count_q  <= BND_COUNT_RST;
			elem_count_q <= ELEM_COUNT_RST;
			tol_q        <= TOL_RST;
			cursor_q     <= '0;
			prev_q       <= '0;
			seen_q       <= 1'b0;
			exh_q        <= 1'b0;
			abort_q      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_BND_COUNT:  bnd_count_q  <= cfg.data[CNT_W-1:0];
					CFG_ELEM_COUNT: elem_count_q <= cfg.data[ELEM_W-1:0];
					CFG_TOLERANCE:  tol_q        <= cfg.data[TOL_W-1:0];
					default: ;
				endcase
			end

			if (early_load || snap_go) begin
				cursor_q <= cursor_eff;
				seen_q   <= snap_go ? 1'b1 : seen_eff;
				exh_q    <= exh_nxt;
				abort_q  <= abort_nxt;
				if (snap_go)
					prev_q <= req.sample;
			end else if (adv_any) begin
				cursor_q <= cur_next;
				if (cur_last)
					exh_q <= 1'b1;
			end

			if (early_load || ((state_q == CS_EMIT) && out_free))
				out_valid_q <= 1'b1;
			else if (rsp.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (snap_go) begin
			x_q   <= req.sample;
			pos_q <= req.position;
		end
		if (cmp_term && !adv_go) begin
			res_value_q  <= (cmp_rsp.verdict == VERD_SNAP) ? mem_rdata : VAL_W'(x_q);
			res_status_q <= res_status_c;
		end
		if (early_load) begin
			out_pos_q    <= req.position;
			out_value_q  <= VAL_W'(req.sample);
			out_status_q <= early_status;
		end else if ((state_q == CS_EMIT) && out_free) begin
			out_pos_q    <= pos_q;
			out_value_q  <= res_value_q;
			out_status_q <= res_status_q;
		end
	end

	// checks
	`SBS_ASSERT_NOW(a_cursor_in_range, clk, arst_n, state_q == CS_FETCH, cursor_q < count_eff, "table read past boundary count")
	`SBS_ASSERT_NOW(a_flags_exclusive, clk, arst_n, 1'b1, !(exh_q && abort_q), "pass both exhausted and aborted")
	`SBS_ASSERT_NOW(a_cmp_done_owned, clk, arst_n, cmp_rsp.done, state_q == CS_CMP, "compare finished outside compare state")
	`SBS_ASSERT_NEXT(a_emit_loads, clk, arst_n, (state_q == CS_EMIT) && out_free, rsp.valid, "pending result not presented")

endmodule

FILE: hdl/sbs_bnd_mem.sv
// Boundary table: single write port, single registered read port.
// Depends on sbs_pkg. Contents undefined until written.
module sbs_bnd_mem #(
	parameter int DEPTH = sbs_pkg::SBS_MAX_BOUNDARIES,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [AW-1:0]            wr_addr,
	input  logic [sbs_pkg::VAL_W-1:0] wr_data,
	input  logic                     rd_en,
	input  logic [AW-1:0]            rd_addr,
	output logic [sbs_pkg::VAL_W-1:0] rd_data
);
	import sbs_pkg::*;

	logic [VAL_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
		if (rd_en)
			rd_data <= mem_q[rd_addr];
	end

endmodule

FILE: hdl/sbs_cmp.sv
// Near-equality test of a value against one boundary, absolute or relative.
// Depends on sbs_pkg. Relative test uses one shared 33x32 multiplier twice.
module sbs_cmp (
	input  logic              clk,
	input  logic              arst_n,
	input  sbs_pkg::cmp_req_t req,
	output sbs_pkg::cmp_rsp_t rsp
);
	import sbs_pkg::*;

	cmp_phase_t        phase_q, phase_d;
	logic              neg_q;
	logic [VAL_W-1:0]  mag_q, ab_q;
	logic [PROD_W-1:0] lo_q, hi_q;
	logic [SUM_W-1:0]  sum_q;

	logic              neg_c;
	logic [VAL_W-1:0]  mag_c, ab_c;
	logic              rel, big_abs, big_rel, big;
	logic [HALF_W-1:0] mul_b;
	logic [PROD_W-1:0] mul_p;

	// signed difference magnitude and |b|, latched at start
	always_comb begin
		neg_c = $signed(req.x) < $signed(req.b);
		mag_c = neg_c ? VAL_W'(req.b - req.x) : VAL_W'(req.x - req.b);
		ab_c  = req.b[VAL_W-1] ? VAL_W'(VAL_W'(0) - req.b) : VAL_W'(req.b);
	end

	always_comb begin
		rel     = ab_q > VAL_W'(req.tol);
		big_abs = mag_q >= VAL_W'(req.tol);
		big_rel = {1'b0, mag_q, HALF_W'(0)} >= sum_q;
		mul_b   = (phase_q == CP_EVAL) ? ab_q[HALF_W-1:0] : ab_q[VAL_W-1:HALF_W];
		mul_p   = PROD_W'(req.tol) * PROD_W'(mul_b);
	end

	// next phase
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			CP_IDLE:   if (req.start) phase_d = CP_EVAL;
			CP_EVAL:   phase_d = rel ? CP_MUL_HI : CP_IDLE;
			CP_MUL_HI: phase_d = CP_SUM;
			CP_SUM:    phase_d = CP_REL;
			CP_REL:    phase_d = CP_IDLE;
			default:   phase_d = CP_IDLE;
		endcase
	end

	// verdict
	always_comb begin
		big         = (phase_q == CP_EVAL) ? big_abs : big_rel;
		rsp.done    = ((phase_q == CP_EVAL) && !rel) || (phase_q == CP_REL);
		rsp.verdict = !big ? VERD_SNAP : (neg_q ? VERD_BELOW : VERD_ADVANCE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			phase_q <= CP_IDLE;
		else
			phase_q <= phase_d;
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= neg_c;
			mag_q <= mag_c;
			ab_q  <= ab_c;
		end
		if (phase_q == CP_EVAL)
			lo_q <= mul_p;
		if (phase_q == CP_MUL_HI)
			hi_q <= mul_p;
		if (phase_q == CP_SUM)
			sum_q <= SUM_W'(lo_q) + {hi_q, HALF_W'(0)};
	end

endmodule

FILE: dv/snap_result_checker.sv
`timescale 1ns / 100ps
// Checker for the boundary snap core: watches request, result and register channels,
// predicts every snap result and compares it. Depends on sbs_pkg and sbs_if.
module snap_result_checker (
	input  logic clk,
	input  logic arst_n,
	sbs_req_if   req,
	sbs_rsp_if   rsp,
	sbs_cfg_if   cfg,
	output int   mismatches,
	output int   awaiting,
	output int   results_checked,
	output int   snapped_seen
);
	import sbs_pkg::*;

	typedef struct packed {
		logic [POS_W-1:0]        pos;
		logic signed [VAL_W-1:0] value;
		status_t                 status;
	} snap_outcome_t;

	// predictor state
	logic signed [VAL_W-1:0] bnd_table [SBS_MAX_BOUNDARIES];
	logic [CNT_W-1:0]        cursor;
	logic signed [VAL_W-1:0] last_value;
	logic                    seen_value;
	logic                    table_done;
	logic                    pass_dead;
	logic [CNT_W-1:0]        bnd_count;
	logic [ELEM_W-1:0]       elem_count;
	logic [TOL_W-1:0]        tol;
	snap_outcome_t           expected_snaps [$];
	snap_outcome_t           want;

	// where x sits against boundary b: relative band when |b| > tol, else absolute
	function automatic verdict_t judge(input logic signed [VAL_W-1:0] x,
			input logic signed [VAL_W-1:0] b);
		logic [VAL_W-1:0] gap;
		logic [VAL_W-1:0] mag_b;
		logic [127:0]     lhs;
		logic [127:0]     rhs;
		logic             below;
		logic             big;
		below = x < b;
		gap = below ? b - x : x - b;
		mag_b = b[VAL_W-1] ? -b : b;
		if (mag_b > VAL_W'(tol)) begin
			lhs = {32'd0, gap, 32'd0};
			rhs = 128'(tol) * 128'(mag_b);
			big = lhs >= rhs;
		end else begin
			big = gap >= VAL_W'(tol);
		end
		if (big)
			return below ? VERD_BELOW : VERD_ADVANCE;
		return VERD_SNAP;
	endfunction

	function automatic snap_outcome_t predict_snap(input logic [POS_W-1:0] pos,
			input logic signed [VAL_W-1:0] x, input logic first);
		snap_outcome_t    res;
		logic [CNT_W-1:0] live;
		verdict_t         v;
		logic             settled;
		if (first) begin
			cursor = '0;
			seen_value = 1'b0;
			table_done = 1'b0;
			pass_dead = 1'b0;
		end
		live = (bnd_count > CNT_W'(SBS_MAX_BOUNDARIES)) ? CNT_W'(SBS_MAX_BOUNDARIES) : bnd_count;
		res.pos = pos;
		res.value = x;
		if (pass_dead) begin
			res.status = STAT_ABORTED;
		end else if (table_done || cursor >= live) begin
			table_done = 1'b1;
			res.status = STAT_PAST_LAST;
		end else if (ELEM_W'(pos) >= elem_count) begin
			pass_dead = 1'b1;
			res.status = STAT_POS_ERR;
		end else if (seen_value && x < last_value) begin
			pass_dead = 1'b1;
			res.status = STAT_ORDER_ERR;
		end else begin
			last_value = x;
			seen_value = 1'b1;
			res.status = STAT_PAST_LAST;
			settled = 1'b0;
			while (!settled && cursor < live) begin
				v = judge(x, bnd_table[cursor[SLOT_W-1:0]]);
				if (v == VERD_ADVANCE) begin
					cursor = cursor + 1'b1;
				end else begin
					settled = 1'b1;
					if (v == VERD_BELOW) begin
						res.status = STAT_KEPT;
					end else begin
						res.status = STAT_SNAPPED;
						res.value = bnd_table[cursor[SLOT_W-1:0]];
					end
				end
			end
			if (!settled)
				table_done = 1'b1;
		end
		return res;
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			cursor = '0;
			last_value = '0;
			seen_value = 1'b0;
			table_done = 1'b0;
			pass_dead = 1'b0;
			bnd_count = BND_COUNT_RST;
			elem_count = ELEM_COUNT_RST;
			tol = TOL_RST;
			expected_snaps.delete();
			mismatches = 0;
			results_checked = 0;
			snapped_seen = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_BND_COUNT:  bnd_count = cfg.data[CNT_W-1:0];
					CFG_ELEM_COUNT: elem_count = cfg.data[ELEM_W-1:0];
					CFG_TOLERANCE:  tol = cfg.data[TOL_W-1:0];
					default: ;
				endcase
			end
			if (rsp.valid && rsp.ready) begin
				results_checked++;
				if (rsp.status == STAT_SNAPPED)
					snapped_seen++;
				if (expected_snaps.size() == 0) begin
					$error("result with no snap outstanding: position %0d value %0d status %0d",
						rsp.out_position, rsp.out_value, rsp.status);
					mismatches++;
				end else begin
					want = expected_snaps.pop_front();
					if (rsp.out_position !== want.pos) begin
						$error("out_position: expected %0d, got %0d", want.pos, rsp.out_position);
						mismatches++;
					end
					if (rsp.out_value !== want.value) begin
						$error("out_value: expected %0d, got %0d", want.value, rsp.out_value);
						mismatches++;
					end
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.status);
						mismatches++;
					end
				end
			end
			if (req.valid && req.ready) begin
				if (req.operation == OP_WRITE_BND)
					bnd_table[req.boundary_slot] = req.sample;
				else
					expected_snaps = {expected_snaps,
						predict_snap(req.position, req.sample, req.first_of_pass)};
			end
		end
		awaiting = expected_snaps.size();
	end

endmodule

FILE: dv/sorted_boundary_snap_core_tb.sv
`timescale 1ns / 100ps
// Top of the boundary snap core testbench: clock, reset, stimulus and verdict.
// Depends on sbs_pkg, sbs_if, sorted_boundary_snap_core and snap_result_checker.
module sorted_boundary_snap_core_tb;
	import sbs_pkg::*;

	localparam int CLK_HALF    = 10;
	localparam int RESET_TICKS = 10;
	localparam int ITEM_TARGET = 1450;
	localparam int LONG_HOLD   = 400;   // receiver hold-off, long enough to back up the input
	localparam int SETTLE_GAP  = 8;     // margin for a trailing table write to retire
	localparam int DRAIN_GAP   = 50;

	localparam logic signed [VAL_W-1:0] VAL_MIN  = {1'b1, {(VAL_W-1){1'b0}}};
	localparam logic signed [VAL_W-1:0] VAL_MAX  = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic [TOL_W-1:0]        TOL_FULL = {1'b1, {(TOL_W-1){1'b0}}};

	logic clk;
	logic arst_n;

	sbs_req_if req_ch ();
	sbs_rsp_if rsp_ch ();
	sbs_cfg_if cfg_ch ();

	int mismatches;
	int awaiting;
	int results_checked;
	int snapped_seen;

	// idling knobs, read by the drivers each cycle
	int   gap_pct;
	int   stall_pct;
	logic want_hold;
	int   hold_left;

	int n_snaps;
	int n_writes;
	int n_regs;
	int n_phases;

	// our view of the register settings and table, used only to aim the stimulus
	logic [CNT_W-1:0]        cur_count;
	logic [ELEM_W-1:0]       cur_elem;
	logic [TOL_W-1:0]        cur_tol;
	logic signed [VAL_W-1:0] shadow [SBS_MAX_BOUNDARIES];

	sorted_boundary_snap_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	snap_result_checker u_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.req             (req_ch),
		.rsp             (rsp_ch),
		.cfg             (cfg_ch),
		.mismatches      (mismatches),
		.awaiting        (awaiting),
		.results_checked (results_checked),
		.snapped_seen    (snapped_seen)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// hard stop, far beyond the slowest legal run
	initial begin
		#20000000;
		$display("CHECK FAILED");
		$finish;
	end

	// result side: random stalls, plus the odd long hold-off counted here
	initial begin
		rsp_ch.ready = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (want_hold) begin
				hold_left = LONG_HOLD;
				want_hold = 1'b0;
			end
			if (hold_left > 0) begin
				rsp_ch.ready = 1'b0;
				hold_left--;
			end else begin
				rsp_ch.ready = ($urandom_range(99) >= stall_pct);
			end
		end
	end

	function automatic logic [VAL_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// b + d, clamped to the Q32.32 range
	function automatic logic signed [VAL_W-1:0] offset_sat(input logic signed [VAL_W-1:0] b,
			input logic signed [VAL_W:0] d);
		logic signed [VAL_W+1:0] s;
		s = b + d;
		if (s > VAL_MAX)
			return VAL_MAX;
		if (s < VAL_MIN)
			return VAL_MIN;
		return s[VAL_W-1:0];
	endfunction

	// width of the near-equality band around b under the current tolerance
	function automatic logic [VAL_W-1:0] near_band(input logic signed [VAL_W-1:0] b);
		logic [VAL_W-1:0] mag;
		logic [127:0]     prod;
		mag = b[VAL_W-1] ? -b : b;
		if (mag > VAL_W'(cur_tol)) begin
			prod = 128'(cur_tol) * 128'(mag);
			return prod[95:32];
		end
		return VAL_W'(cur_tol);
	endfunction

	// offsets that land on, just inside and just outside the band edges, plus scaled and small random ones
	function automatic logic signed [VAL_W:0] pick_delta(input logic [VAL_W-1:0] band);
		logic signed [VAL_W:0] t;
		logic signed [VAL_W:0] r;
		t = {1'b0, band};
		case ($urandom_range(9))
			0: return '0;
			1: return t;
			2: return -t;
			3: return t - 1;
			4: return -t + 1;
			5: return t + 1;
			6: return -t - 1;
			7: begin
				r = t >>> $urandom_range(1, 8);
				return $urandom_range(1) ? r : -r;
			end
			8: return (VAL_W+1)'($urandom) << $urandom_range(0, 31);
			default: return (VAL_W+1)'($urandom_range(8)) - 4;
		endcase
	endfunction

	// positions: mostly in range, a stray one now and then when the range allows
	function automatic logic [POS_W-1:0] pick_position(input logic stray);
		if (cur_elem == '0)
			return POS_W'($urandom);
		if (stray && cur_elem <= ELEM_W'(65535))
			return POS_W'($urandom_range(65535, cur_elem));
		return POS_W'($urandom_range(cur_elem - 1, 0));
	endfunction

	// one request transaction; entered and left at a falling edge, valid left high
	task automatic send(input logic op, input logic [SLOT_W-1:0] slot,
			input logic [POS_W-1:0] pos, input logic signed [VAL_W-1:0] value,
			input logic first);
		while ($urandom_range(99) < gap_pct) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.operation = op;
		req_ch.boundary_slot = slot;
		req_ch.position = pos;
		req_ch.sample = value;
		req_ch.first_of_pass = first;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		@(negedge clk);
		if (op == OP_SNAP) begin
			n_snaps++;
		end else begin
			n_writes++;
			shadow[slot] = value;
		end
	endtask

	// first_of_pass is don't-care on a table write, so it is randomised
	task automatic write_slot(input logic [SLOT_W-1:0] slot,
			input logic signed [VAL_W-1:0] value);
		send(OP_WRITE_BND, slot, POS_W'($urandom), value, 1'($urandom_range(1)));
	endtask

	task automatic snap(input logic [POS_W-1:0] pos, input logic signed [VAL_W-1:0] x,
			input logic first);
		send(OP_SNAP, SLOT_W'($urandom), pos, x, first);
	endtask

	// sender pauses until every result is in, then lets a trailing write retire
	task automatic settle();
		req_ch.valid = 1'b0;
		wait (awaiting == 0);
		repeat (SETTLE_GAP) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = idx;
		cfg_ch.data = data;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
		n_regs++;
		case (idx)
			CFG_BND_COUNT:  cur_count = data[CNT_W-1:0];
			CFG_ELEM_COUNT: cur_elem = data[ELEM_W-1:0];
			CFG_TOLERANCE:  cur_tol = data[TOL_W-1:0];
			default: ;
		endcase
	endtask

	// registers only change with the block drained
	task automatic configure(input logic [CNT_W-1:0] count, input logic [ELEM_W-1:0] elems,
			input logic [TOL_W-1:0] tol);
		settle();
		write_reg(CFG_BND_COUNT, CFG_DATA_W'(count));
		write_reg(CFG_ELEM_COUNT, CFG_DATA_W'(elems));
		write_reg(CFG_TOLERANCE, CFG_DATA_W'(tol));
	endtask

	// ascending table with random base and step size; rare unsorted entries as noise
	task automatic load_table(input int n);
		logic signed [VAL_W-1:0] v;
		int step_bits;
		int i;
		v = $signed(rand64()) >>> $urandom_range(0, 40);
		step_bits = $urandom_range(0, 60);
		if ($urandom_range(3) == 0)
			v = VAL_MIN;
		for (i = 0; i < n; i++) begin
			if (i == n - 1 && $urandom_range(5) == 0)
				v = VAL_MAX;
			if ($urandom_range(15) == 0)
				write_slot(SLOT_W'(i), rand64());
			else
				write_slot(SLOT_W'(i), v);
			v = offset_sat(v, (VAL_W+1)'(rand64() >> (64 - step_bits)));
		end
	endtask

	// One pass: values walk up the table, each aimed at a band edge of some boundary.
	// Noise: a falling value, a stray position, a restart mid-pass, a table rewrite.
	task automatic run_pass(input int len);
		logic signed [VAL_W-1:0] x;
		logic signed [VAL_W-1:0] floor_x;
		logic [CNT_W-1:0]        live;
		logic [SLOT_W-1:0]       s;
		logic                    lead;
		int                      k;
		int                      i;
		live = (cur_count > CNT_W'(SBS_MAX_BOUNDARIES)) ? CNT_W'(SBS_MAX_BOUNDARIES) : cur_count;
		k = 0;
		floor_x = VAL_MIN;
		lead = 1'b1;
		for (i = 0; i < len; i++) begin
			if (live == '0) begin
				x = rand64();
			end else begin
				if ($urandom_range(2) == 0)
					k = k + $urandom_range(1, 3);
				if (k >= live)
					k = live - 1;
				x = offset_sat(shadow[k], pick_delta(near_band(shadow[k])));
			end
			if (!lead && $urandom_range(24) == 0) begin
				x = offset_sat(floor_x, -(VAL_W+1)'($urandom_range(1, 1000)));
			end else begin
				if (x < floor_x)
					x = floor_x;
				floor_x = x;
			end
			if (!lead && $urandom_range(49) == 0)
				lead = 1'b1;
			snap(pick_position($urandom_range(24) == 0), x, lead);
			lead = 1'b0;
			if ($urandom_range(49) == 0) begin
				s = SLOT_W'($urandom);
				write_slot(s, offset_sat(shadow[s], pick_delta(64'd4)));
			end
		end
	endtask

	task automatic set_idling(input int mode);
		case (mode)
			1: begin gap_pct = 54; stall_pct = 0;  end
			2: begin gap_pct = 0;  stall_pct = 54; end
			3: begin gap_pct = 13; stall_pct = 13; end
			default: begin gap_pct = 0; stall_pct = 0; end
		endcase
	endtask

	initial begin
		int i;
		logic [CNT_W-1:0]  pick_count;
		logic [ELEM_W-1:0] pick_elem;
		logic [TOL_W-1:0]  pick_tol;

		// every block input known from time zero
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.operation = OP_WRITE_BND;
		req_ch.boundary_slot = '0;
		req_ch.position = '0;
		req_ch.sample = '0;
		req_ch.first_of_pass = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_BND_COUNT;
		cfg_ch.data = '0;
		want_hold = 1'b0;
		gap_pct = 0;
		stall_pct = 0;
		n_snaps = 0;
		n_writes = 0;
		n_regs = 0;
		n_phases = 0;
		cur_count = BND_COUNT_RST;
		cur_elem = ELEM_COUNT_RST;
		cur_tol = TOL_RST;

		repeat (RESET_TICKS) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Fill every slot once so no later pass can read an entry never written.
		for (i = 0; i < SBS_MAX_BOUNDARIES; i++)
			write_slot(SLOT_W'(i), (VAL_W)'(i) << 36);

		// ---- directed: range extremes, both operations, the corner cases ----
		configure(4, 65536, 64);
		send(OP_WRITE_BND, 0, 0, VAL_MIN, 1'b1);
		send(OP_WRITE_BND, 1, 16'hffff, -64'sd100, 1'b0);
		send(OP_WRITE_BND, 2, 0, 64'sd1 << 40, 1'b0);
		send(OP_WRITE_BND, 3, 0, VAL_MAX, 1'b1);
		send(OP_WRITE_BND, 255, 0, VAL_MAX, 1'b1);
		snap(0, VAL_MIN, 1'b1);                      // exact hit on the most negative entry
		snap(65535, -64'sd101, 1'b0);                // just below a small relative band
		snap(1, -64'sd100, 1'b0);
		snap(2, (64'sd1 << 40) - 255, 1'b0);         // inside the relative band
		snap(3, (64'sd1 << 40) + 16384, 1'b0);       // on the upper edge: moves on
		snap(4, VAL_MAX, 1'b0);
		snap(5, VAL_MAX, 1'b0);
		// falling value aborts the pass; the next one reports the abort
		snap(6, 64'sd10, 1'b1);
		snap(7, 64'sd9, 1'b0);
		snap(8, 64'sd11, 1'b0);

		// zero tolerance: an exact match steps past; position at the element limit
		configure(2, 100, 0);
		send(OP_WRITE_BND, 0, 0, 64'sd5, 1'b0);
		send(OP_WRITE_BND, 1, 0, 64'sd5, 1'b0);
		snap(100, 64'sd7, 1'b1);
		snap(0, 64'sd7, 1'b0);
		snap(99, 64'sd5, 1'b1);
		snap(1, 64'sd6, 1'b0);

		// empty table, then zero element count with a saturating boundary count
		configure(0, 0, TOL_FULL);
		snap(0, 64'sd0, 1'b1);
		snap(1, 64'sd5, 1'b0);
		configure(300, 0, TOL_FULL);
		snap(0, 64'sd3, 1'b1);
		configure(300, 65536, TOL_FULL);
		snap(2, VAL_MIN, 1'b1);
		snap(3, VAL_MAX, 1'b0);

		// ---- random phases: new settings and table each, several passes ----
		while (n_snaps + n_writes < ITEM_TARGET) begin
			n_phases++;
			case ($urandom_range(9))
				0, 1, 2, 3, 4, 5: pick_count = CNT_W'($urandom_range(1, 8));
				6: pick_count = CNT_W'($urandom_range(9, SBS_MAX_BOUNDARIES));
				7: pick_count = CNT_W'(SBS_MAX_BOUNDARIES);
				8: pick_count = CNT_W'(1);
				default: pick_count = $urandom_range(1) ? CNT_W'(0) : CNT_W'($urandom_range(257, 511));
			endcase
			case ($urandom_range(5))
				0, 1, 2: pick_elem = ELEM_W'(65536);
				3: pick_elem = ELEM_W'($urandom_range(1, 65535));
				4: pick_elem = ELEM_W'(1);
				default: pick_elem = ELEM_W'($urandom_range(0, 20));
			endcase
			case ($urandom_range(6))
				0: pick_tol = TOL_RST;
				1: pick_tol = '0;
				2: pick_tol = TOL_W'(1);
				3: pick_tol = TOL_FULL;
				4: pick_tol = {1'($urandom_range(1)), $urandom};
				5: pick_tol = TOL_W'($urandom_range(0, 1 << 20));
				default: pick_tol = TOL_W'($urandom_range(0, 255));
			endcase
			configure(pick_count, pick_elem, pick_tol);
			set_idling(n_phases % 4);
			load_table((pick_count > CNT_W'(SBS_MAX_BOUNDARIES)) ? SBS_MAX_BOUNDARIES
				: int'(pick_count));
			// receiver goes quiet while the sender keeps offering transactions
			if (n_phases == 1 || $urandom_range(7) == 0)
				want_hold = 1'b1;
			repeat ($urandom_range(1, 3))
				run_pass($urandom_range(3, 30));
		end

		settle();
		repeat (DRAIN_GAP) @(negedge clk);

		$display("Run: %0d snap and %0d table-write transactions, %0d register writes, %0d random settings.",
			n_snaps, n_writes, n_regs, n_phases);
		$display("Results compared: %0d, of which %0d snapped to a boundary.",
			results_checked, snapped_seen);
		if (mismatches == 0 && awaiting == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
